@@ sv/qhrsa_pkg.sv @@
// Shared constants and controller/datapath interface types for the hash-and-sign block.
package qhrsa_pkg;

   localparam int MOD_WIDTH_DEF = 31;

   // Register reset values and register indexes
   localparam int MODULUS_RST  = 3;
   localparam int PRIV_EXP_RST = 1;
   localparam int PUB_EXP_RST  = 2;
   localparam int SEED_RST     = 100;

   localparam int REG_MODULUS  = 0;
   localparam int REG_PRIV_EXP = 1;
   localparam int REG_PUB_EXP  = 2;
   localparam int REG_SEED     = 3;

   // Modular multiply operand selection; also selects where the result lands
   typedef enum logic [2:0] {
      OP_NONE     = 3'd0,
      OP_RED_HASH = 3'd1,  // (hash + byte) mod m
      OP_SQ_HASH  = 3'd2,  // hash * hash mod m
      OP_RED_SIG  = 3'd3,  // signature mod m
      OP_EXP_MUL  = 3'd4,  // acc * base mod m
      OP_EXP_SQ   = 3'd5   // base * base mod m
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
      logic   use_seed;
      logic   exp_init;
      logic   exp_shift;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic mm_done;
      logic exp_zero;
      logic exp_bit;
      logic last;
      logic verify;
   } sts_type;

endpackage

@@ sv/qhrsa_datapath.sv @@
// Datapath: hash, exponentiation registers and a bit-serial shift-add modular multiplier.
module qhrsa_datapath #(
   parameter int MOD_WIDTH = qhrsa_pkg::MOD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  qhrsa_pkg::cmd_type     cmd,
   output qhrsa_pkg::sts_type     sts,
   input  logic [MOD_WIDTH-1:0]   modulus,
   input  logic [MOD_WIDTH-1:0]   private_exponent,
   input  logic [MOD_WIDTH-1:0]   public_exponent,
   input  logic [MOD_WIDTH-1:0]   hash_seed,
   input  logic                   command,
   input  logic [7:0]             data_byte,
   input  logic                   last,
   input  logic [MOD_WIDTH-1:0]   given_signature,
   output logic [MOD_WIDTH-1:0]   final_hash,
   output logic [MOD_WIDTH-1:0]   signature_value,
   output logic                   signature_ok
);

   localparam int W     = MOD_WIDTH;
   localparam int CNT_W = $clog2(W + 2);
   localparam logic [CNT_W-1:0] STEPS = CNT_W'(W + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

   logic [W-1:0] m_eff;
   logic [W-1:0] one_mod;

   logic [W-1:0] hash_ff, hash_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] exp_ff, exp_in;
   logic [W-1:0] sig_ff, sig_in;
   logic         last_ff, last_in;
   logic         verify_ff, verify_in;

   logic [W-1:0]     mm_x_ff, mm_x_in;
   logic [W:0]       mm_y_ff, mm_y_in;
   logic [W-1:0]     mm_acc_ff, mm_acc_in;
   qhrsa_pkg::op_type op_ff, op_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [W-1:0] x_start;
   logic [W:0]   y_start;
   logic [W-1:0] hash_sel;
   logic [W:0]   dbl, dbl_red, sum, sum_red;
   logic [W-1:0] step_res;
   logic         finish;

   // A modulus of zero or one behaves as one: every residue is zero
   assign m_eff   = (modulus < W'(2)) ? W'(1) : modulus;
   assign one_mod = (modulus > W'(1)) ? W'(1) : '0;

   assign hash_sel = cmd.use_seed ? hash_seed : hash_ff;

   always_comb begin
      unique case (cmd.op)
         qhrsa_pkg::OP_RED_HASH: begin
            x_start = one_mod;
            y_start = (W+1)'(hash_sel) + (W+1)'(data_byte);
         end
         qhrsa_pkg::OP_SQ_HASH: begin
            x_start = hash_ff;
            y_start = {1'b0, hash_ff};
         end
         qhrsa_pkg::OP_RED_SIG: begin
            x_start = one_mod;
            y_start = {1'b0, sig_ff};
         end
         qhrsa_pkg::OP_EXP_MUL: begin
            x_start = base_ff;
            y_start = {1'b0, acc_ff};
         end
         qhrsa_pkg::OP_EXP_SQ: begin
            x_start = base_ff;
            y_start = {1'b0, base_ff};
         end
         default: begin
            x_start = '0;
            y_start = '0;
         end
      endcase
   end

   // One multiplier bit per cycle, MSB first: acc = (2*acc + bit*x) mod m
   assign dbl      = {mm_acc_ff, 1'b0};
   assign dbl_red  = (dbl >= (W+1)'(m_eff)) ? dbl - (W+1)'(m_eff) : dbl;
   assign sum      = dbl_red + (mm_y_ff[W] ? (W+1)'(mm_x_ff) : '0);
   assign sum_red  = (sum >= (W+1)'(m_eff)) ? sum - (W+1)'(m_eff) : sum;
   assign step_res = sum_red[W-1:0];
   assign finish   = busy_ff && (cnt_ff == CNT_LAST);

   always_comb begin
      mm_x_in   = mm_x_ff;
      mm_y_in   = mm_y_ff;
      mm_acc_in = mm_acc_ff;
      op_in     = op_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      done_in   = finish;
      if (cmd.start) begin
         mm_x_in   = x_start;
         mm_y_in   = y_start;
         mm_acc_in = '0;
         op_in     = cmd.op;
         busy_in   = 1'b1;
         cnt_in    = STEPS;
      end else if (busy_ff) begin
         mm_acc_in = step_res;
         mm_y_in   = {mm_y_ff[W-1:0], 1'b0};
         cnt_in    = cnt_ff - CNT_LAST;
         busy_in   = !finish;
      end
   end

   always_comb begin
      hash_in   = hash_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      exp_in    = exp_ff;
      sig_in    = sig_ff;
      last_in   = last_ff;
      verify_in = verify_ff;
      if (cmd.start && (cmd.op == qhrsa_pkg::OP_RED_HASH)) begin
         sig_in    = given_signature;
         last_in   = last;
         verify_in = command;
      end
      if (finish) begin
         unique case (op_ff)
            qhrsa_pkg::OP_RED_HASH, qhrsa_pkg::OP_SQ_HASH: hash_in = step_res;
            qhrsa_pkg::OP_RED_SIG,  qhrsa_pkg::OP_EXP_SQ:  base_in = step_res;
            qhrsa_pkg::OP_EXP_MUL:                         acc_in  = step_res;
            default: ;
         endcase
      end
      if (cmd.exp_init) begin
         acc_in = one_mod;
         exp_in = verify_ff ? public_exponent : private_exponent;
         if (!verify_ff) begin
            base_in = hash_ff;
         end
      end else if (cmd.exp_shift) begin
         exp_in = exp_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= qhrsa_pkg::OP_NONE;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      mm_x_ff   <= mm_x_in;
      mm_y_ff   <= mm_y_in;
      mm_acc_ff <= mm_acc_in;
      hash_ff   <= hash_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      exp_ff    <= exp_in;
      sig_ff    <= sig_in;
      last_ff   <= last_in;
      verify_ff <= verify_in;
   end

   assign sts.mm_done  = done_ff;
   assign sts.exp_zero = (exp_ff == '0);
   assign sts.exp_bit  = exp_ff[0];
   assign sts.last     = last_ff;
   assign sts.verify   = verify_ff;

   assign final_hash      = hash_ff;
   assign signature_value = acc_ff;
   assign signature_ok    = verify_ff && (acc_ff == hash_ff);

endmodule

@@ sv/qhrsa_ctrl.sv @@
// Controller: sequences hash update, signature reduction and square-and-multiply.
module qhrsa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic               out_free,
   input  qhrsa_pkg::sts_type sts,
   output qhrsa_pkg::cmd_type cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_RED    = 7'b0000010,
      ST_SQ     = 7'b0000100,
      ST_SIGRED = 7'b0001000,
      ST_EXP    = 7'b0010000,
      ST_MUL    = 7'b0100000,
      ST_SQR    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      in_msg_ff, in_msg_in;
   logic      out_wait_ff, out_wait_in;

   assign req_tready = (state_ff == ST_IDLE) && !out_wait_ff;

   always_comb begin
      state_in     = state_ff;
      in_msg_in    = in_msg_ff;
      out_wait_in  = out_wait_ff;
      cmd          = '0;
      cmd.op       = qhrsa_pkg::OP_NONE;
      // result waiting for the output register
      if (out_wait_ff && out_free) begin
         cmd.out_load = 1'b1;
         out_wait_in  = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.start    = 1'b1;
               cmd.op       = qhrsa_pkg::OP_RED_HASH;
               cmd.use_seed = !in_msg_ff;
               state_in     = ST_RED;
            end
         end
         ST_RED: begin
            if (sts.mm_done) begin
               cmd.start = 1'b1;
               cmd.op    = qhrsa_pkg::OP_SQ_HASH;
               state_in  = ST_SQ;
            end
         end
         ST_SQ: begin
            if (sts.mm_done) begin
               in_msg_in = !sts.last;
               if (!sts.last) begin
                  state_in = ST_IDLE;
               end else if (sts.verify) begin
                  cmd.start = 1'b1;
                  cmd.op    = qhrsa_pkg::OP_RED_SIG;
                  state_in  = ST_SIGRED;
               end else begin
                  cmd.exp_init = 1'b1;
                  state_in     = ST_EXP;
               end
            end
         end
         ST_SIGRED: begin
            if (sts.mm_done) begin
               cmd.exp_init = 1'b1;
               state_in     = ST_EXP;
            end
         end
         ST_EXP: begin
            priority if (sts.exp_zero) begin
               out_wait_in = 1'b1;
               state_in    = ST_IDLE;
            end else if (sts.exp_bit) begin
               cmd.start = 1'b1;
               cmd.op    = qhrsa_pkg::OP_EXP_MUL;
               state_in  = ST_MUL;
            end else begin
               cmd.start     = 1'b1;
               cmd.op        = qhrsa_pkg::OP_EXP_SQ;
               cmd.exp_shift = 1'b1;
               state_in      = ST_SQR;
            end
         end
         ST_MUL: begin
            if (sts.mm_done) begin
               cmd.start     = 1'b1;
               cmd.op        = qhrsa_pkg::OP_EXP_SQ;
               cmd.exp_shift = 1'b1;
               state_in      = ST_SQR;
            end
         end
         ST_SQR: begin
            if (sts.mm_done) begin
               state_in = ST_EXP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_msg_ff   <= 1'b0;
         out_wait_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_msg_ff   <= in_msg_in;
         out_wait_ff <= out_wait_in;
      end
   end

endmodule

@@ sv/quadratic_hash_rsa_signature.sv @@
// Top level: quadratic-hash message digest with modular-exponentiation sign and verify.
// Each non-last byte takes two passes of the bit-serial modular multiplier (reduce, then square)
//   before the next byte is accepted. A last byte then adds a signature-reduction pass on verify,
//   a square per exponent bit up to the top set bit and a multiply per set bit; the next byte
//   is accepted once the result has moved to the output register.
// Sync active-high reset: seed reloads, config regs take reset values, no result pending.
module quadratic_hash_rsa_signature #(
   parameter int MOD_WIDTH = qhrsa_pkg::MOD_WIDTH_DEF,
   localparam int W           = MOD_WIDTH,
   localparam int IN_DATA_W   = ((8 + W + 7) / 8) * 8,
   localparam int OUT_DATA_W  = ((2 * W + 1 + 7) / 8) * 8,
   localparam int CSR_DATA_W  = (W > 32) ? 64 : 32,
   localparam int CSR_STEP_LG = (W > 32) ? 3 : 2,
   localparam int CSR_ADDR_W  = CSR_STEP_LG + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] data_byte, [MOD_WIDTH+7:8] given_signature, zero padding above
   input  logic [IN_DATA_W-1:0]  req_tdata,
   input  logic                  req_tlast,   // last
   input  logic                  req_tuser,   // command: 0 sign, 1 verify
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [MOD_WIDTH-1:0] final_hash, [2*MOD_WIDTH-1:MOD_WIDTH] signature_value,
   // [2*MOD_WIDTH] signature_ok, zero padding above
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [W-1:0] modulus_ff, modulus_in;
   logic [W-1:0] priv_exp_ff, priv_exp_in;
   logic [W-1:0] pub_exp_ff, pub_exp_in;
   logic [W-1:0] seed_ff, seed_in;
   logic [1:0]   csr_idx;
   logic         csr_wr;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   qhrsa_pkg::cmd_type cmd;
   qhrsa_pkg::sts_type sts;
   logic [W-1:0] final_hash;
   logic [W-1:0] signature_value;
   logic         signature_ok;
   logic         out_free;

   // Register file: every address maps, low byte-offset bits ignored
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:CSR_STEP_LG];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      modulus_in  = modulus_ff;
      priv_exp_in = priv_exp_ff;
      pub_exp_in  = pub_exp_ff;
      seed_in     = seed_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            2'(qhrsa_pkg::REG_MODULUS):  modulus_in  = csr_pwdata[W-1:0];
            2'(qhrsa_pkg::REG_PRIV_EXP): priv_exp_in = csr_pwdata[W-1:0];
            2'(qhrsa_pkg::REG_PUB_EXP):  pub_exp_in  = csr_pwdata[W-1:0];
            2'(qhrsa_pkg::REG_SEED):     seed_in     = csr_pwdata[W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         2'(qhrsa_pkg::REG_MODULUS):  csr_prdata = CSR_DATA_W'(modulus_ff);
         2'(qhrsa_pkg::REG_PRIV_EXP): csr_prdata = CSR_DATA_W'(priv_exp_ff);
         2'(qhrsa_pkg::REG_PUB_EXP):  csr_prdata = CSR_DATA_W'(pub_exp_ff);
         2'(qhrsa_pkg::REG_SEED):     csr_prdata = CSR_DATA_W'(seed_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff  <= W'(qhrsa_pkg::MODULUS_RST);
         priv_exp_ff <= W'(qhrsa_pkg::PRIV_EXP_RST);
         pub_exp_ff  <= W'(qhrsa_pkg::PUB_EXP_RST);
         seed_ff     <= W'(qhrsa_pkg::SEED_RST);
      end else begin
         modulus_ff  <= modulus_in;
         priv_exp_ff <= priv_exp_in;
         pub_exp_ff  <= pub_exp_in;
         seed_ff     <= seed_in;
      end
   end

   qhrsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .sts        (sts),
      .cmd        (cmd)
   );

   qhrsa_datapath #(
      .MOD_WIDTH (MOD_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .modulus          (modulus_ff),
      .private_exponent (priv_exp_ff),
      .public_exponent  (pub_exp_ff),
      .hash_seed        (seed_ff),
      .command          (req_tuser),
      .data_byte        (req_tdata[7:0]),
      .last             (req_tlast),
      .given_signature  (req_tdata[W+7:8]),
      .final_hash       (final_hash),
      .signature_value  (signature_value),
      .signature_ok     (signature_ok)
   );

   // Output register: result holds here while the next message streams in
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = OUT_DATA_W'({signature_ok, signature_value, final_hash});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
